// ===== rtl/core/bvs_pkg.sv =====
// Shared types and constants for the BILOU Viterbi step block.
`timescale 1ns / 1ps
package bvs_pkg;

   localparam int PROB_W   = 16;
   localparam int ENT_IO_W = 8;
   localparam int TAG_W    = 3;
   localparam int NUM_TAGS = 5;

   typedef enum logic [TAG_W-1:0] {
      TAG_B    = 3'd0,
      TAG_I    = 3'd1,
      TAG_L    = 3'd2,
      TAG_O    = 3'd3,
      TAG_U    = 3'd4,
      TAG_NONE = 3'd5
   } tag_type;

   typedef struct packed {
      logic                 load;
      logic                 select;
      logic                 div_step;
      logic                 mul_en;
      logic [TAG_W-1:0]     mul_idx;
      logic                 finish;
   } dp_cmd_type;

   typedef struct packed {
      logic first;
   } dp_status_type;

endpackage

// ===== rtl/core/bvs_if.sv =====
// Item channel interfaces for the token input and the step result.
`timescale 1ns / 1ps
interface bvs_req_if;
   logic        valid;
   logic        ready;
   logic        first_token;
   logic [15:0] local_prob_b;
   logic [15:0] local_prob_i;
   logic [15:0] local_prob_l;
   logic [15:0] local_prob_o;
   logic [15:0] local_prob_u;
   logic [7:0]  local_entity_b;
   logic [7:0]  local_entity_i;
   logic [7:0]  local_entity_l;
   logic [7:0]  local_entity_o;
   logic [7:0]  local_entity_u;

   modport source (output valid, first_token, local_prob_b, local_prob_i, local_prob_l,
                   local_prob_o, local_prob_u, local_entity_b, local_entity_i,
                   local_entity_l, local_entity_o, local_entity_u, input ready);
   modport sink (input valid, first_token, local_prob_b, local_prob_i, local_prob_l,
                 local_prob_o, local_prob_u, local_entity_b, local_entity_i,
                 local_entity_l, local_entity_o, local_entity_u, output ready);
endinterface

interface bvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] back_b;
   logic [2:0] back_i;
   logic [2:0] back_l;
   logic [2:0] back_o;
   logic [2:0] back_u;
   logic [2:0] best_tag;
   logic [7:0] entity_of_i;
   logic [7:0] entity_of_l;

   modport source (output valid, back_b, back_i, back_l, back_o, back_u, best_tag,
                   entity_of_i, entity_of_l, input ready);
   modport sink (input valid, back_b, back_i, back_l, back_o, back_u, best_tag,
                 entity_of_i, entity_of_l, output ready);
endinterface

// ===== rtl/core/bilou_viterbi_step.sv =====
// Top level of the BILOU Viterbi forward step.
// One token is taken at a time and its result is held until taken. After
// acceptance, a first token goes through the select and best states; a later
// token also goes through the restoring divider (ratios in Q1.15 by default),
// which produces one ratio bit per cycle, and the single multiplier, which
// forms the five path products one per cycle. The next token is accepted the
// cycle after the result is taken. Path state resets to zero.
`timescale 1ns / 1ps
module bilou_viterbi_step #(
   parameter int PROB_FRAC_BITS = 15,
   parameter int ENTITY_WIDTH   = 8
) (
   input  logic      clock,
   input  logic      reset,
   bvs_req_if.sink   req_if,
   bvs_rsp_if.source rsp_if
);
   import bvs_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [PROB_W-1:0]   in_prob [NUM_TAGS];
   logic [ENT_IO_W-1:0] in_ent  [NUM_TAGS];
   logic [TAG_W-1:0]    out_back [NUM_TAGS];

   assign in_prob[TAG_B] = req_if.local_prob_b;
   assign in_prob[TAG_I] = req_if.local_prob_i;
   assign in_prob[TAG_L] = req_if.local_prob_l;
   assign in_prob[TAG_O] = req_if.local_prob_o;
   assign in_prob[TAG_U] = req_if.local_prob_u;
   assign in_ent[TAG_B]  = req_if.local_entity_b;
   assign in_ent[TAG_I]  = req_if.local_entity_i;
   assign in_ent[TAG_L]  = req_if.local_entity_l;
   assign in_ent[TAG_O]  = req_if.local_entity_o;
   assign in_ent[TAG_U]  = req_if.local_entity_u;

   bvs_ctrl #(
      .PROB_FRAC_BITS(PROB_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bvs_dp #(
      .PROB_FRAC_BITS(PROB_FRAC_BITS),
      .ENTITY_WIDTH  (ENTITY_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_first  (req_if.first_token),
      .in_prob   (in_prob),
      .in_ent    (in_ent),
      .out_back  (out_back),
      .out_best  (rsp_if.best_tag),
      .out_ent_i (rsp_if.entity_of_i),
      .out_ent_l (rsp_if.entity_of_l)
   );

   assign rsp_if.back_b = out_back[TAG_B];
   assign rsp_if.back_i = out_back[TAG_I];
   assign rsp_if.back_l = out_back[TAG_L];
   assign rsp_if.back_o = out_back[TAG_O];
   assign rsp_if.back_u = out_back[TAG_U];

endmodule

// ===== rtl/core/bvs_ctrl.sv =====
// Sequencer: accept, select, divide, multiply, pick best, deliver.
`timescale 1ns / 1ps
module bvs_ctrl #(
   parameter int PROB_FRAC_BITS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bvs_pkg::dp_status_type status,
   output bvs_pkg::dp_cmd_type    cmd
);
   import bvs_pkg::*;

   localparam int DIV_STEPS = PROB_FRAC_BITS + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEL, ST_DIV, ST_MUL, ST_BEST, ST_RESP
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [TAG_W-1:0]   idx_ff;
   logic               req_ready_ff;
   logic               rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_SEL;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_SEL: begin
               cnt_ff   <= '0;
               idx_ff   <= '0;
               state_ff <= status.first ? ST_BEST : ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_ff <= ST_MUL;
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_MUL: begin
               if (idx_ff == TAG_W'(NUM_TAGS - 1)) state_ff <= ST_BEST;
               idx_ff <= idx_ff + 1'b1;
            end
            ST_BEST: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = req_valid && req_ready_ff;
      cmd.select   = (state_ff == ST_SEL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.mul_en   = (state_ff == ST_MUL);
      cmd.mul_idx  = idx_ff;
      cmd.finish   = (state_ff == ST_BEST);
   end

endmodule

// ===== rtl/core/bvs_dp.sv =====
// Datapath: path state, restoring divider, shared multiplier, result registers.
`timescale 1ns / 1ps
module bvs_dp #(
   parameter int PROB_FRAC_BITS = 15,
   parameter int ENTITY_WIDTH   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bvs_pkg::dp_cmd_type    cmd,
   output bvs_pkg::dp_status_type status,
   input  logic                   in_first,
   input  logic [bvs_pkg::PROB_W-1:0]   in_prob [bvs_pkg::NUM_TAGS],
   input  logic [bvs_pkg::ENT_IO_W-1:0] in_ent  [bvs_pkg::NUM_TAGS],
   output logic [bvs_pkg::TAG_W-1:0]    out_back [bvs_pkg::NUM_TAGS],
   output logic [bvs_pkg::TAG_W-1:0]    out_best,
   output logic [bvs_pkg::ENT_IO_W-1:0] out_ent_i,
   output logic [bvs_pkg::ENT_IO_W-1:0] out_ent_l
);
   import bvs_pkg::*;

   localparam int FW   = PROB_FRAC_BITS + 1;           // factor width, holds ONE
   localparam int MW   = FW + PROB_W;                  // product width
   localparam int EWX  = (ENTITY_WIDTH > ENT_IO_W) ? ENTITY_WIDTH : ENT_IO_W;
   localparam logic [FW-1:0] ONE = FW'(64'd1 << PROB_FRAC_BITS);
   localparam logic [MW-1:0] ONE_EXT = MW'(64'd1 << PROB_FRAC_BITS);
   localparam logic [PROB_W-1:0] ONE_SAT =
      (PROB_FRAC_BITS < PROB_W) ? PROB_W'(64'd1 << PROB_FRAC_BITS) : '1;

   logic [PROB_W-1:0]       local_ff [NUM_TAGS];
   logic [ENTITY_WIDTH-1:0] ent_ff   [NUM_TAGS];
   logic                    first_ff;
   logic [PROB_W-1:0]       path_prob_ff   [NUM_TAGS];
   logic [ENTITY_WIDTH-1:0] path_entity_ff [NUM_TAGS];
   logic [TAG_W-1:0]        back_ff [NUM_TAGS];
   logic [TAG_W-1:0]        best_ff;
   logic [ENT_IO_W-1:0]     ent_i_ff, ent_l_ff;

   logic [PROB_W:0]         rem_ff;
   logic [PROB_W-1:0]       large_ff;
   logic [FW-1:0]           quo_ff;
   logic                    bi_gt_ff;
   logic                    zero_ff;

   // selection
   logic [TAG_W-1:0]        lou_tag, bi_tag;
   logic [PROB_W-1:0]       lou_p, bi_p;
   logic                    bi_gt;
   // divider
   logic                    div_ge;
   logic [PROB_W:0]         div_sub;
   // multiplier
   logic [FW-1:0]           f_small, f_lou, f_bi, factor;
   logic [MW-1:0]           product;
   // best search
   logic [TAG_W-1:0]        best_tag;
   logic [PROB_W-1:0]       best_p;
   logic [EWX-1:0]          ent_wide_i, ent_wide_l;

   always_comb begin
      lou_tag = TAG_L;
      lou_p   = path_prob_ff[TAG_L];
      if (path_prob_ff[TAG_O] > lou_p) begin
         lou_tag = TAG_O;
         lou_p   = path_prob_ff[TAG_O];
      end
      if (path_prob_ff[TAG_U] > lou_p) begin
         lou_tag = TAG_U;
         lou_p   = path_prob_ff[TAG_U];
      end
      bi_tag = TAG_B;
      bi_p   = path_prob_ff[TAG_B];
      if (path_prob_ff[TAG_I] > bi_p) begin
         bi_tag = TAG_I;
         bi_p   = path_prob_ff[TAG_I];
      end
      bi_gt = bi_p > lou_p;
   end

   assign div_ge  = rem_ff >= {1'b0, large_ff};
   assign div_sub = div_ge ? (rem_ff - {1'b0, large_ff}) : rem_ff;

   // both maxima zero: the ratio is forced to zero
   assign f_small = zero_ff ? '0 : quo_ff;
   assign f_lou   = bi_gt_ff ? f_small : ONE;
   assign f_bi    = bi_gt_ff ? ONE : f_small;

   always_comb begin
      case (cmd.mul_idx) inside
         TAG_I, TAG_L: factor = f_bi;
         default:      factor = f_lou;
      endcase
      product = MW'(factor) * MW'(local_ff[cmd.mul_idx]);
   end

   always_comb begin
      best_tag = TAG_B;
      best_p   = path_prob_ff[TAG_B];
      for (int t = 1; t < NUM_TAGS; t++) begin
         if (path_prob_ff[t] > best_p) begin
            best_tag = TAG_W'(t);
            best_p   = path_prob_ff[t];
         end
      end
      ent_wide_i = EWX'(path_entity_ff[TAG_I]);
      ent_wide_l = EWX'(path_entity_ff[TAG_L]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TAGS; t++) begin
            path_prob_ff[t]   <= '0;
            path_entity_ff[t] <= '0;
         end
      end else begin
         if (cmd.load) begin
            first_ff <= in_first;
            for (int t = 0; t < NUM_TAGS; t++) begin
               local_ff[t] <= (MW'(in_prob[t]) > ONE_EXT) ? ONE_SAT : in_prob[t];
               ent_ff[t]   <= ENTITY_WIDTH'(EWX'(in_ent[t]));
            end
         end
         if (cmd.select) begin
            if (first_ff) begin
               for (int t = 0; t < NUM_TAGS; t++) begin
                  path_prob_ff[t]   <= local_ff[t];
                  path_entity_ff[t] <= ent_ff[t];
                  back_ff[t]        <= TAG_NONE;
               end
               path_prob_ff[TAG_I] <= '0;
               path_prob_ff[TAG_L] <= '0;
            end else begin
               bi_gt_ff <= bi_gt;
               large_ff <= bi_gt ? bi_p : lou_p;
               rem_ff   <= {1'b0, (bi_gt ? lou_p : bi_p)};
               zero_ff  <= (lou_p == '0) && !bi_gt;
               quo_ff   <= '0;
               path_entity_ff[TAG_B] <= ent_ff[TAG_B];
               path_entity_ff[TAG_I] <= path_entity_ff[bi_tag];
               path_entity_ff[TAG_L] <= path_entity_ff[bi_tag];
               path_entity_ff[TAG_O] <= ent_ff[TAG_O];
               path_entity_ff[TAG_U] <= ent_ff[TAG_U];
               back_ff[TAG_B] <= lou_tag;
               back_ff[TAG_I] <= bi_tag;
               back_ff[TAG_L] <= bi_tag;
               back_ff[TAG_O] <= lou_tag;
               back_ff[TAG_U] <= lou_tag;
            end
         end
         if (cmd.div_step) begin
            quo_ff <= {quo_ff[FW-2:0], div_ge};
            rem_ff <= {div_sub[PROB_W-1:0], 1'b0};
         end
         if (cmd.mul_en) begin
            path_prob_ff[cmd.mul_idx] <= product[PROB_FRAC_BITS +: PROB_W];
         end
         if (cmd.finish) begin
            best_ff  <= best_tag;
            ent_i_ff <= ENT_IO_W'(ent_wide_i);
            ent_l_ff <= ENT_IO_W'(ent_wide_l);
         end
      end
   end

   assign status.first = first_ff;
   assign out_back     = back_ff;
   assign out_best     = best_ff;
   assign out_ent_i    = ent_i_ff;
   assign out_ent_l    = ent_l_ff;

endmodule

// ===== rtl/core/bvs_checker.sv =====
// Port-level assertions for the Viterbi step, bound to the top level.
`timescale 1ns / 1ps
module bvs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] back_b,
   input logic [2:0] back_i,
   input logic [2:0] back_l,
   input logic [2:0] back_o,
   input logic [2:0] back_u
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before taken");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open while result pending");

   a_lou_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (back_b == back_o) && (back_o == back_u))
      else $error("B/O/U back pointers differ");

   a_bi_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (back_i == back_l))
      else $error("I/L back pointers differ");

endmodule

bind bilou_viterbi_step bvs_checker u_bvs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .back_b    (rsp_if.back_b),
   .back_i    (rsp_if.back_i),
   .back_l    (rsp_if.back_l),
   .back_o    (rsp_if.back_o),
   .back_u    (rsp_if.back_u)
);

// ===== tb/tb_bilou_viterbi_step.sv =====
// Self-checking testbench for the BILOU Viterbi step block.
`timescale 1ns / 1ps
module tb_bilou_viterbi_step;
   import bvs_pkg::*;

   typedef struct {
      logic        first;
      logic [15:0] prob [5];
      logic [7:0]  ent [5];
   } token_type;

   typedef struct {
      logic [2:0] back [5];
      logic [2:0] best;
      logic [7:0] ent_i;
      logic [7:0] ent_l;
   } step_out_type;

   localparam int FRAC = 15;
   localparam logic [31:0] ONE = 32'd1 << FRAC;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bvs_req_if req_if ();
   bvs_rsp_if rsp_if ();

   bilou_viterbi_step u_top (.clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if));

   logic [31:0]  path_p [5];
   logic [7:0]   path_e [5];
   step_out_type pending_steps [$];
   int           errors = 0;
   int           cycles = 0;
   int           n_tokens = 0;
   int           n_checked = 0;
   bit           quiet = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // forward step of the predictor
   function automatic step_out_type viterbi_step(token_type tk);
      step_out_type r;
      logic [31:0] loc [5];
      logic [31:0] lou_p, bi_p, f_lou, f_bi;
      logic [2:0]  lou, bi;
      logic [7:0]  inh;
      int          best;
      for (int t = 0; t < 5; t++)
         loc[t] = (tk.prob[t] > ONE) ? ONE : {16'd0, tk.prob[t]};
      if (tk.first) begin
         for (int t = 0; t < 5; t++) begin
            path_p[t] = loc[t];
            path_e[t] = tk.ent[t];
            r.back[t] = TAG_NONE;
         end
         path_p[TAG_I] = 0;
         path_p[TAG_L] = 0;
      end else begin
         lou = TAG_L; lou_p = path_p[TAG_L];
         bi = TAG_B;  bi_p = path_p[TAG_B];
         if (path_p[TAG_O] > lou_p) begin lou = TAG_O; lou_p = path_p[TAG_O]; end
         if (path_p[TAG_U] > lou_p) begin lou = TAG_U; lou_p = path_p[TAG_U]; end
         if (path_p[TAG_I] > bi_p) begin bi = TAG_I; bi_p = path_p[TAG_I]; end
         if (bi_p > lou_p) begin
            f_lou = (lou_p << FRAC) / bi_p;
            f_bi = ONE;
         end else begin
            f_bi = (lou_p != 0) ? (bi_p << FRAC) / lou_p : 0;
            f_lou = ONE;
         end
         inh = path_e[bi];
         path_p[TAG_B] = (f_lou * loc[TAG_B]) >> FRAC;
         path_p[TAG_I] = (f_bi * loc[TAG_I]) >> FRAC;
         path_p[TAG_L] = (f_bi * loc[TAG_L]) >> FRAC;
         path_p[TAG_O] = (f_lou * loc[TAG_O]) >> FRAC;
         path_p[TAG_U] = (f_lou * loc[TAG_U]) >> FRAC;
         path_e[TAG_B] = tk.ent[TAG_B];
         path_e[TAG_I] = inh;
         path_e[TAG_L] = inh;
         path_e[TAG_O] = tk.ent[TAG_O];
         path_e[TAG_U] = tk.ent[TAG_U];
         r.back[TAG_B] = lou;
         r.back[TAG_I] = bi;
         r.back[TAG_L] = bi;
         r.back[TAG_O] = lou;
         r.back[TAG_U] = lou;
      end
      best = 0;
      for (int t = 1; t < 5; t++)
         if (path_p[t] > path_p[best]) best = t;
      r.best = best[2:0];
      r.ent_i = path_e[TAG_I];
      r.ent_l = path_e[TAG_L];
      return r;
   endfunction

   task automatic send_token(token_type tk);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.first_token <= tk.first;
      req_if.local_prob_b <= tk.prob[0];
      req_if.local_prob_i <= tk.prob[1];
      req_if.local_prob_l <= tk.prob[2];
      req_if.local_prob_o <= tk.prob[3];
      req_if.local_prob_u <= tk.prob[4];
      req_if.local_entity_b <= tk.ent[0];
      req_if.local_entity_i <= tk.ent[1];
      req_if.local_entity_l <= tk.ent[2];
      req_if.local_entity_o <= tk.ent[3];
      req_if.local_entity_u <= tk.ent[4];
      do @(posedge clock); while (!req_if.ready);
      pending_steps.push_back(viterbi_step(tk));
      n_tokens++;
   endtask

   task automatic drop_valid();
      req_if.valid <= 1'b0;
   endtask

   // probability with the edges weighted heavily
   function automatic logic [15:0] pick_prob();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'hFFFF;
         3: return 16'($urandom_range(32769, 65535));
         4: return 16'($urandom_range(1, 4));
         5: return 16'($urandom_range(32760, 32768));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic token_type rand_token(bit first);
      token_type tk;
      tk.first = first;
      for (int t = 0; t < 5; t++) begin
         tk.prob[t] = pick_prob();
         tk.ent[t] = 8'($urandom_range(0, 255));
      end
      return tk;
   endfunction

   function automatic token_type fixed_token(bit first, logic [15:0] p, logic [7:0] e);
      token_type tk;
      tk.first = first;
      for (int t = 0; t < 5; t++) begin
         tk.prob[t] = p;
         tk.ent[t] = e + t[7:0];
      end
      return tk;
   endfunction

   task automatic test_directed();
      token_type tk;
      // update straight after reset works on zero state
      send_token(fixed_token(1'b0, 16'd12345, 8'd10));
      send_token(fixed_token(1'b1, 16'd0, 8'd0));
      send_token(fixed_token(1'b0, 16'd0, 8'd250));  // both maxima zero
      send_token(fixed_token(1'b1, 16'hFFFF, 8'd255));  // saturation
      send_token(fixed_token(1'b0, 16'hFFFF, 8'd1));
      send_token(fixed_token(1'b0, 16'd32768, 8'd7));
      tk = fixed_token(1'b1, 16'd100, 8'd20);
      tk.prob[TAG_O] = 16'd30000;
      send_token(tk);
      tk = fixed_token(1'b0, 16'd1, 8'd40);
      tk.prob[TAG_I] = 16'd32768;
      send_token(tk);  // L/O/U path wins, small ratio
      tk.prob[TAG_B] = 16'd0;
      tk.prob[TAG_U] = 16'd32768;
      send_token(tk);
      send_token(fixed_token(1'b0, 16'd16384, 8'd60));
      tk = fixed_token(1'b1, 16'd0, 8'd80);
      tk.prob[TAG_U] = 16'd5;
      send_token(tk);
      send_token(fixed_token(1'b0, 16'd32767, 8'd90));
      send_token(fixed_token(1'b0, 16'd32767, 8'd95));
      drop_valid();
   endtask

   task automatic test_random_sentences(int count);
      int left;
      left = count;
      while (left > 0) begin
         send_token(rand_token(($urandom_range(0, 19) == 0) ? 1'b0 : 1'b1));
         left--;
         for (int k = $urandom_range(0, 10); k > 0 && left > 0; k--) begin
            send_token(rand_token(1'b0));
            left--;
         end
      end
      drop_valid();
   endtask

   task automatic test_full_rate(int count);
      quiet = 1'b1;
      for (int n = 0; n < count; n++)
         send_token(rand_token($urandom_range(0, 7) == 0));
      drop_valid();
   endtask

   // result sink: random stalls (none in full-rate mode), compare against oldest expectation
   always @(posedge clock) begin
      step_out_type exp_s;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_steps.size() == 0) begin
               $error("unexpected result");
               errors++;
            end else begin
               exp_s = pending_steps.pop_front();
               n_checked++;
               if (rsp_if.back_b !== exp_s.back[0]) begin
                  $error("back_b exp %0d got %0d", exp_s.back[0], rsp_if.back_b); errors++;
               end
               if (rsp_if.back_i !== exp_s.back[1]) begin
                  $error("back_i exp %0d got %0d", exp_s.back[1], rsp_if.back_i); errors++;
               end
               if (rsp_if.back_l !== exp_s.back[2]) begin
                  $error("back_l exp %0d got %0d", exp_s.back[2], rsp_if.back_l); errors++;
               end
               if (rsp_if.back_o !== exp_s.back[3]) begin
                  $error("back_o exp %0d got %0d", exp_s.back[3], rsp_if.back_o); errors++;
               end
               if (rsp_if.back_u !== exp_s.back[4]) begin
                  $error("back_u exp %0d got %0d", exp_s.back[4], rsp_if.back_u); errors++;
               end
               if (rsp_if.best_tag !== exp_s.best) begin
                  $error("best_tag exp %0d got %0d", exp_s.best, rsp_if.best_tag); errors++;
               end
               if (rsp_if.entity_of_i !== exp_s.ent_i) begin
                  $error("entity_of_i exp %0d got %0d", exp_s.ent_i, rsp_if.entity_of_i);
                  errors++;
               end
               if (rsp_if.entity_of_l !== exp_s.ent_l) begin
                  $error("entity_of_l exp %0d got %0d", exp_s.ent_l, rsp_if.entity_of_l);
                  errors++;
               end
            end
         end
         rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.first_token <= 1'b0;
      req_if.local_prob_b <= '0;
      req_if.local_prob_i <= '0;
      req_if.local_prob_l <= '0;
      req_if.local_prob_o <= '0;
      req_if.local_prob_u <= '0;
      req_if.local_entity_b <= '0;
      req_if.local_entity_i <= '0;
      req_if.local_entity_l <= '0;
      req_if.local_entity_o <= '0;
      req_if.local_entity_u <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int t = 0; t < 5; t++) begin
         path_p[t] = 0;
         path_e[t] = 0;
      end
      test_directed();
      test_random_sentences(1000);
      test_full_rate(200);
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Ran %0d tokens (directed edges, random sentences, full rate); %0d results checked",
               n_tokens, n_checked);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
